@@ rtl/grid_disk_obstacle_marker_top_assert.svh @@
// Assertion macros for the grid disk obstacle marker RTL.
// Depends on nothing; expects clk and rst_n in the including module.
`ifndef GRID_DISK_OBSTACLE_MARKER_TOP_ASSERT_SVH
`define GRID_DISK_OBSTACLE_MARKER_TOP_ASSERT_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define GDOM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define GDOM_NEVER(lbl, cond, msg) \
  `GDOM_ASSERT(lbl, !(cond), msg)
`else
`define GDOM_ASSERT(lbl, prop, msg)
`define GDOM_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/gdom_pkg.sv @@
// Shared widths, register map, reset values and control structs
// for the grid disk obstacle marker. No dependencies.
package gdom_pkg;

  localparam int MAX_OFFSET = 3;

  localparam int COORD_W = 12;
  localparam int NODE_W  = 14;
  localparam int RAD_W   = 10;
  localparam int SPC_W   = 8;

  localparam int HW_W   = $clog2(MAX_OFFSET + 1);
  localparam int IDX_W  = $clog2(2 * MAX_OFFSET + 1);
  localparam int HS_W   = HW_W + SPC_W;
  localparam int CMP_W  = RAD_W + HS_W;

  localparam int DIV_STEPS = COORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int DIFF_W = NODE_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int R2_W   = 2 * RAD_W;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FIELD_WIDTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIELD_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEEPOUT_RADIUS = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_GRID_SPACING   = 2'd3;

  localparam logic [COORD_W-1:0] RST_FIELD_WIDTH    = 12'd900;
  localparam logic [COORD_W-1:0] RST_FIELD_HEIGHT   = 12'd600;
  localparam logic [RAD_W-1:0]   RST_KEEPOUT_RADIUS = 10'd20;
  localparam logic [SPC_W-1:0]   RST_GRID_SPACING   = 8'd10;

  typedef struct packed {
    logic [COORD_W-1:0] field_width;
    logic [COORD_W-1:0] field_height;
    logic [RAD_W-1:0]   keepout_radius;
    logic [SPC_W-1:0]   grid_spacing;
  } cfg_t;

  typedef struct packed {
    logic load;      // latch point, start remainder, latch half-width
    logic div_step;  // one remainder bit for x and y
    logic setup;     // compute sweep start and r^2
    logic issue;     // push current node into the pipe
    logic col_wrap;  // node closes a column of the sweep
    logic last;      // node closes the sweep
  } dp_cmd_t;

  typedef struct packed {
    logic [HW_W-1:0] half_width;
    logic            pipe_busy;
    logic            adv;
  } dp_stat_t;

endpackage

@@ rtl/gdom_if.sv @@
// Valid/ready channel interfaces for points in and swept nodes out.
// Depends on gdom_pkg.
interface gdom_in_if import gdom_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface gdom_out_if import gdom_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [NODE_W-1:0] node_x;
  logic signed [NODE_W-1:0] node_y;
  logic                     blocked;
  logic                     visible;
  logic                     last_node;

  modport source (output valid, node_x, node_y, blocked, visible, last_node, input ready);
  modport sink   (input valid, node_x, node_y, blocked, visible, last_node, output ready);
endinterface

@@ rtl/gdom_regs.sv @@
// APB configuration registers: field bounds, keep-out radius, grid spacing.
// Depends on gdom_pkg.
module gdom_regs import gdom_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_width    <= RST_FIELD_WIDTH;
      cfg_r.field_height   <= RST_FIELD_HEIGHT;
      cfg_r.keepout_radius <= RST_KEEPOUT_RADIUS;
      cfg_r.grid_spacing   <= RST_GRID_SPACING;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FIELD_WIDTH:    cfg_r.field_width    <= pwdata[COORD_W-1:0];
        REG_FIELD_HEIGHT:   cfg_r.field_height   <= pwdata[COORD_W-1:0];
        REG_KEEPOUT_RADIUS: cfg_r.keepout_radius <= pwdata[RAD_W-1:0];
        REG_GRID_SPACING:   cfg_r.grid_spacing   <= pwdata[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIELD_WIDTH:    prdata = APB_DATA_W'(cfg_r.field_width);
      REG_FIELD_HEIGHT:   prdata = APB_DATA_W'(cfg_r.field_height);
      REG_KEEPOUT_RADIUS: prdata = APB_DATA_W'(cfg_r.keepout_radius);
      REG_GRID_SPACING:   prdata = APB_DATA_W'(cfg_r.grid_spacing);
      default:            prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/gdom_ctrl.sv @@
// Sequencer: accept, remainder steps, setup, then the row/column node sweep.
// Depends on gdom_pkg and grid_disk_obstacle_marker_top_assert.svh.
`include "grid_disk_obstacle_marker_top_assert.svh"

module gdom_ctrl import gdom_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] span;
  logic             col_end;
  logic             row_end;

  // last offset index is 2h
  assign span    = IDX_W'({stat.half_width, 1'b0});
  assign col_end = (col_r == span);
  assign row_end = (row_r == span);

  // hold off new points until the front of the pipe has drained
  assign in_ready = (state_r == ST_IDLE) && !stat.pipe_busy;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        row_nxt   = '0;
        col_nxt   = '0;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (stat.adv) begin
          cmd.issue    = 1'b1;
          cmd.col_wrap = col_end;
          cmd.last     = col_end && row_end;
          if (col_end) begin
            col_nxt = '0;
            row_nxt = row_r + IDX_W'(1);
          end else begin
            col_nxt = col_r + IDX_W'(1);
          end
          if (col_end && row_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  `GDOM_ASSERT(a_last_ends_sweep, cmd.issue && cmd.last |=> state_r == ST_IDLE, "sweep did not end on last node")
  `GDOM_ASSERT(a_col_in_span, state_r == ST_SWEEP |-> col_r <= span, "column index past sweep span")
  `GDOM_ASSERT(a_row_in_span, state_r == ST_SWEEP |-> row_r <= span, "row index past sweep span")
  `GDOM_NEVER(a_issue_on_stall, cmd.issue && !stat.adv, "node issued while output stalled")

endmodule

@@ rtl/gdom_dp.sv @@
// Datapath: bit-serial remainder for grid snapping, node coordinate stepping,
// and a stall-all pipe of squares, distance compare and output register.
// Depends on gdom_pkg.
module gdom_dp import gdom_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic [COORD_W-1:0]       point_x,
  input  logic [COORD_W-1:0]       point_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [NODE_W-1:0] node_x,
  output logic signed [NODE_W-1:0] node_y,
  output logic                     blocked,
  output logic                     visible,
  output logic                     last_node
);

  logic [SPC_W-1:0]   s_eff;
  logic [HW_W-1:0]    h_calc;
  logic [HW_W-1:0]    h_r;
  logic [COORD_W-1:0] px_r, py_r;
  logic [COORD_W-1:0] sx_r, sy_r;
  logic [SPC_W-1:0]   rem_x_r, rem_y_r;
  logic [SPC_W:0]     tx, ty;
  logic [SPC_W-1:0]   rem_x_nxt, rem_y_nxt;
  logic [HS_W-1:0]    hs;
  logic [R2_W-1:0]    r2_r;
  logic signed [NODE_W-1:0] cur_x_r, cur_y_r, y_start_r, step;
  logic               adv;

  // stage 0: node coordinates
  logic                     s0_valid_r;
  logic signed [NODE_W-1:0] s0_x_r, s0_y_r;
  logic                     s0_last_r;
  // stage 1: squares and field test
  logic                     s1_valid_r;
  logic signed [NODE_W-1:0] s1_x_r, s1_y_r;
  logic [SQ_W-1:0]          s1_sqx_r, s1_sqy_r;
  logic                     s1_in_r;
  logic                     s1_last_r;
  // output register
  logic                     out_valid_r;
  logic signed [NODE_W-1:0] node_x_r, node_y_r;
  logic                     blocked_r, visible_r, last_r;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [SQ_W-1:0]   sqx, sqy;
  logic                     in_x, in_y;
  logic [D2_W-1:0]          d2;

  assign s_eff = (cfg.grid_spacing == '0) ? SPC_W'(1) : cfg.grid_spacing;
  assign adv   = !out_valid_r || out_ready;

  // h = floor(r/s)+1 saturated: count the multiples of s that r reaches
  always_comb begin
    h_calc = HW_W'(1);
    for (int k = 1; k < MAX_OFFSET; k++) begin
      if (CMP_W'(cfg.keepout_radius) >= CMP_W'(HS_W'(k) * HS_W'(s_eff))) begin
        h_calc = h_calc + HW_W'(1);
      end
    end
  end

  // restoring remainder, one bit per step, MSB first
  assign tx = {rem_x_r, sx_r[COORD_W-1]};
  assign ty = {rem_y_r, sy_r[COORD_W-1]};
  assign rem_x_nxt = (tx >= {1'b0, s_eff}) ? SPC_W'(tx - {1'b0, s_eff}) : tx[SPC_W-1:0];
  assign rem_y_nxt = (ty >= {1'b0, s_eff}) ? SPC_W'(ty - {1'b0, s_eff}) : ty[SPC_W-1:0];

  assign hs   = HS_W'(h_r) * HS_W'(s_eff);
  assign step = $signed(NODE_W'(s_eff));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r    <= point_x;
      py_r    <= point_y;
      sx_r    <= point_x;
      sy_r    <= point_y;
      rem_x_r <= '0;
      rem_y_r <= '0;
      h_r     <= h_calc;
    end
    if (cmd.div_step) begin
      sx_r    <= sx_r << 1;
      sy_r    <= sy_r << 1;
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
    end
    if (cmd.setup) begin
      cur_x_r   <= $signed(NODE_W'(px_r) - NODE_W'(rem_x_r) - NODE_W'(hs));
      cur_y_r   <= $signed(NODE_W'(py_r) - NODE_W'(rem_y_r) - NODE_W'(hs));
      y_start_r <= $signed(NODE_W'(py_r) - NODE_W'(rem_y_r) - NODE_W'(hs));
      r2_r      <= R2_W'(cfg.keepout_radius) * R2_W'(cfg.keepout_radius);
    end
    if (cmd.issue) begin
      if (cmd.col_wrap) begin
        cur_x_r <= cur_x_r + step;
        cur_y_r <= y_start_r;
      end else begin
        cur_y_r <= cur_y_r + step;
      end
    end
  end

  // stage 1 logic
  assign dx   = $signed(DIFF_W'(px_r)) - $signed({s0_x_r[NODE_W-1], s0_x_r});
  assign dy   = $signed(DIFF_W'(py_r)) - $signed({s0_y_r[NODE_W-1], s0_y_r});
  assign sqx  = dx * dx;
  assign sqy  = dy * dy;
  assign in_x = !s0_x_r[NODE_W-1] && (s0_x_r[NODE_W-2:0] <= (NODE_W-1)'(cfg.field_width));
  assign in_y = !s0_y_r[NODE_W-1] && (s0_y_r[NODE_W-2:0] <= (NODE_W-1)'(cfg.field_height));

  // stage 2 logic
  assign d2 = D2_W'(s1_sqx_r) + D2_W'(s1_sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r  <= cmd.issue;
      s1_valid_r  <= s0_valid_r;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x_r    <= cur_x_r;
      s0_y_r    <= cur_y_r;
      s0_last_r <= cmd.last;

      s1_x_r    <= s0_x_r;
      s1_y_r    <= s0_y_r;
      s1_sqx_r  <= sqx;
      s1_sqy_r  <= sqy;
      s1_in_r   <= in_x && in_y;
      s1_last_r <= s0_last_r;

      node_x_r  <= s1_x_r;
      node_y_r  <= s1_y_r;
      blocked_r <= s1_in_r && (d2 <= D2_W'(r2_r));
      visible_r <= s1_in_r && ({d2, 2'b00} <= (D2_W + 2)'(r2_r));
      last_r    <= s1_last_r;
    end
  end

  assign stat.half_width = h_r;
  assign stat.pipe_busy  = s0_valid_r || s1_valid_r;
  assign stat.adv        = adv;

  assign out_valid = out_valid_r;
  assign node_x    = node_x_r;
  assign node_y    = node_y_r;
  assign blocked   = blocked_r;
  assign visible   = visible_r;
  assign last_node = last_r;

endmodule

@@ rtl/grid_disk_obstacle_marker_top.sv @@
// Top level of the grid disk obstacle marker: APB registers, sequencer, datapath.
// Depends on gdom_pkg, gdom_if, gdom_regs, gdom_ctrl, gdom_dp.
//
//  port      | dir    | protocol      | payload
//  ----------+--------+---------------+--------------------------------------------
//  in_ch     | sink   | valid/ready   | point_x, point_y (12b unsigned cm)
//  out_ch    | source | valid/ready   | node_x, node_y (14b signed), blocked, visible, last_node
//  APB       | slave  | psel/penable  | 4 regs at 0x0/0x4/0x8/0xC, pready tied high
//
// Per point: accept, then the bit-serial remainder (one bit of the
// 12-bit coordinate per cycle, x and y side by side), setup, then one node per
// cycle while out_ch.ready does not stall the pipe, (2h+1)^2 nodes with
// h = min(radius/spacing + 1, 3). The next point is taken once the last node
// has left the squaring stage.
// Synchronous active-low reset restores the register defaults and empties the pipe.
// out_ch.ready low freezes the whole node pipe; the sweep resumes where it stopped.
module grid_disk_obstacle_marker_top import gdom_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gdom_in_if.sink               in_ch,
  gdom_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // registers never insert wait states
  assign pready = 1'b1;

  gdom_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer owns the input handshake and the sweep counters
  gdom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath owns the output register and its transaction
  gdom_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .point_x   (in_ch.point_x),
    .point_y   (in_ch.point_y),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .node_x    (out_ch.node_x),
    .node_y    (out_ch.node_y),
    .blocked   (out_ch.blocked),
    .visible   (out_ch.visible),
    .last_node (out_ch.last_node)
  );

endmodule

@@ tb/sv/tb_grid_disk_obstacle_marker_top.sv @@
// Self-checking testbench for grid_disk_obstacle_marker_top.
// Depends on gdom_pkg, gdom_if and the marker RTL; needs no other files.
`timescale 1ns / 1ps

module tb_grid_disk_obstacle_marker_top;
  import gdom_pkg::*;

  // Overall cycle budget. The slowest receiver pattern passes one node in four;
  // with ~150 points the run stays well under the limit.
  localparam int CYCLE_LIMIT  = 600000;
  // Idle cycles after the last node: covers the pipe tail and the point hand-off.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 126;
  localparam int RX_HOLD_LEN  = 400;

  // One swept node as it leaves the block.
  typedef struct packed {
    logic signed [NODE_W-1:0] node_x;
    logic signed [NODE_W-1:0] node_y;
    logic                     blocked;
    logic                     visible;
    logic                     last_node;
  } node_t;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  gdom_in_if  in_ch ();
  gdom_out_if out_ch ();

  grid_disk_obstacle_marker_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the register file, kept in step with every APB write.
  logic [COORD_W-1:0] cfg_field_w;
  logic [COORD_W-1:0] cfg_field_h;
  logic [RAD_W-1:0]   cfg_radius;
  logic [SPC_W-1:0]   cfg_spacing;

  node_t pending_nodes[$];   // expected nodes, oldest first
  int    err_count;
  int    cycle_count;

  // Sender burst shaping: burst_left transactions before the next gap.
  int    burst_left;
  bit    sender_gaps;
  // Receiver long hold-off request, picked up by the receiver process.
  int    rx_hold_req;

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sweep predictor: snap the point to the grid, derive the half-width and
  // queue every node of the square, x offset outer, y offset inner.
  // ---------------------------------------------------------------------------
  function automatic void predict_sweep(input logic [COORD_W-1:0] px,
                                        input logic [COORD_W-1:0] py);
    int     spc, hw, bx, by, nx, ny, dx, dy, total, n, pxi, pyi;
    longint d2, r2;
    bit     in_field;
    node_t  nd;
    // zero spacing behaves as spacing 1
    spc   = (cfg_spacing == '0) ? 1 : int'(cfg_spacing);
    pxi   = int'(px);
    pyi   = int'(py);
    bx    = (pxi / spc) * spc;
    by    = (pyi / spc) * spc;
    hw    = int'(cfg_radius) / spc + 1;
    if (hw > MAX_OFFSET) hw = MAX_OFFSET;
    r2    = longint'(cfg_radius) * longint'(cfg_radius);
    total = (2 * hw + 1) * (2 * hw + 1);
    n     = 0;
    for (int i = -hw; i <= hw; i++) begin
      for (int j = -hw; j <= hw; j++) begin
        nx       = bx + i * spc;
        ny       = by + j * spc;
        dx       = pxi - nx;
        dy       = pyi - ny;
        d2       = longint'(dx) * dx + longint'(dy) * dy;
        in_field = (nx >= 0) && (nx <= int'(cfg_field_w)) &&
                   (ny >= 0) && (ny <= int'(cfg_field_h));
        nd.node_x    = nx[NODE_W-1:0];
        nd.node_y    = ny[NODE_W-1:0];
        nd.blocked   = in_field && (d2 <= r2);
        nd.visible   = in_field && (4 * d2 <= r2);
        nd.last_node = (n + 1 == total);
        pending_nodes = {pending_nodes, nd};
        n++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every node transaction is compared with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    node_t exp_nd;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_nodes.size() == 0) begin
        report($sformatf("unexpected node (%0d,%0d)", out_ch.node_x, out_ch.node_y));
      end else begin
        exp_nd = pending_nodes.pop_front();
        if (out_ch.node_x !== exp_nd.node_x)
          report($sformatf("node_x got %0d want %0d", out_ch.node_x, exp_nd.node_x));
        if (out_ch.node_y !== exp_nd.node_y)
          report($sformatf("node_y got %0d want %0d", out_ch.node_y, exp_nd.node_y));
        if (out_ch.blocked !== exp_nd.blocked)
          report($sformatf("blocked got %b want %b at (%0d,%0d)",
                           out_ch.blocked, exp_nd.blocked, exp_nd.node_x, exp_nd.node_y));
        if (out_ch.visible !== exp_nd.visible)
          report($sformatf("visible got %b want %b at (%0d,%0d)",
                           out_ch.visible, exp_nd.visible, exp_nd.node_x, exp_nd.node_y));
        if (out_ch.last_node !== exp_nd.last_node)
          report($sformatf("last_node got %b want %b at (%0d,%0d)",
                           out_ch.last_node, exp_nd.last_node, exp_nd.node_x, exp_nd.node_y));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge. The stall pattern switches
  // at random between always-ready, coin-flip, 3-of-4 and
  // mostly-stalled. A hold-off request drops ready for a counted stretch.
  // ---------------------------------------------------------------------------
  initial begin
    int rx_mode, mode_left, hold_left, phase;
    out_ch.ready = 1'b0;
    rx_mode   = 0;
    mode_left = 100;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = 1'($urandom_range(0, 1));
          2:       out_ch.ready = (phase % 4) != 3;
          default: out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Point sender: one transaction per call. valid stays up across a burst;
  // at the end of a burst it drops for a random gap.
  // ---------------------------------------------------------------------------
  task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    int gap;
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.point_x = px;
    in_ch.point_y = py;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_sweep(px, py);
    if (sender_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        // random gaps land on every stage of a sweep
        gap = $urandom_range(1, 70);
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 8);
      end
    end
  endtask

  // Stop offering points and wait until every expected node has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_nodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // APB access: setup phase, then access phase until pready.
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input bit wr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reads a register and compares it with the shadow copy.
  task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
    logic [APB_DATA_W-1:0] rd, want;
    apb_access(idx, 1'b0, '0, rd);
    case (idx)
      REG_FIELD_WIDTH:    want = APB_DATA_W'(cfg_field_w);
      REG_FIELD_HEIGHT:   want = APB_DATA_W'(cfg_field_h);
      REG_KEEPOUT_RADIUS: want = APB_DATA_W'(cfg_radius);
      default:            want = APB_DATA_W'(cfg_spacing);
    endcase
    if (rd !== want) report($sformatf("reg %0d read %0d want %0d", idx, rd, want));
  endtask

  // Writes a register (block idle), updates the shadow and reads it back.
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned val);
    logic [APB_DATA_W-1:0] rd;
    apb_access(idx, 1'b1, APB_DATA_W'(val), rd);
    case (idx)
      REG_FIELD_WIDTH:    cfg_field_w = val[COORD_W-1:0];
      REG_FIELD_HEIGHT:   cfg_field_h = val[COORD_W-1:0];
      REG_KEEPOUT_RADIUS: cfg_radius  = val[RAD_W-1:0];
      default:            cfg_spacing = val[SPC_W-1:0];
    endcase
    check_reg(idx);
  endtask

  // Lets the block go idle, then writes all four registers.
  task automatic set_all(input int unsigned fw, input int unsigned fh,
                         input int unsigned rad, input int unsigned spc);
    wait_drained();
    set_reg(REG_FIELD_WIDTH, fw);
    set_reg(REG_FIELD_HEIGHT, fh);
    set_reg(REG_KEEPOUT_RADIUS, rad);
    set_reg(REG_GRID_SPACING, spc);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values read back, then points at the coordinate extremes.
  task automatic test_reset_defaults();
    check_reg(REG_FIELD_WIDTH);
    check_reg(REG_FIELD_HEIGHT);
    check_reg(REG_KEEPOUT_RADIUS);
    check_reg(REG_GRID_SPACING);
    send_point(12'd0, 12'd0);        // sweep hangs off the low field edges
    send_point(12'd4095, 12'd4095);  // all nodes outside the field
    send_point(12'd900, 12'd600);    // point on a node at the field corner
    send_point(12'd905, 12'd603);    // off-grid point, snapped down
    send_point(12'd450, 12'd300);
    wait_drained();
  endtask

  // Zero spacing and zero radius; only a node on the point can be flagged.
  task automatic test_zero_cases();
    set_all(0, 0, 0, 0);
    send_point(12'd0, 12'd0);
    send_point(12'd1, 12'd0);
    set_all(100, 100, 0, 7);
    send_point(12'd14, 12'd21);      // exactly on a node
    send_point(12'd15, 12'd22);      // between nodes: nothing flagged
    wait_drained();
  endtask

  // Wide radius saturates the half-width; large spacing with tiny radius.
  task automatic test_extreme_settings();
    set_all(4095, 4095, 1023, 1);
    send_point(12'd4095, 12'd4095);
    send_point(12'd0, 12'd4095);
    set_all(4095, 4095, 1023, 255);
    send_point(12'd4095, 12'd0);     // nodes reach past 4095 and below zero
    send_point(12'd2048, 12'd2047);
    set_all(4095, 0, 1, 255);
    send_point(12'd255, 12'd0);
    // radius 20 at spacing 10: nodes on the rim and at half radius
    set_all(900, 600, 20, 10);
    send_point(12'd20, 12'd20);
    send_point(12'd30, 12'd20);
    wait_drained();
  endtask

  // Random points over a series of random settings.
  task automatic test_random_points();
    int per_phase, fw, fh, rad, spc;
    per_phase = RANDOM_ITEMS / 6;
    for (int ph = 0; ph < 6; ph++) begin
      sender_gaps = (ph != 2);  // one phase runs back to back
      fw  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(2000, 4095);
      fh  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(2000, 4095);
      spc = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 40);
      // radius near a few spacings gives every half-width
      rad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, 3 * (spc + 1)) % 1024;
      set_all(fw, fh, rad, spc);
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(0, 4) == 0)
          send_point(12'($urandom_range(0, 63)), 12'($urandom_range(4032, 4095)));
        else
          send_point(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end
      wait_drained();
    end
    sender_gaps = 1'b1;
  endtask

  // Long receiver hold-off while points keep coming, so the block fills and
  // stalls its input; then a pause until every node has come out.
  task automatic test_backpressure();
    set_all(600, 600, 35, 10);
    rx_hold_req = RX_HOLD_LEN;
    for (int k = 0; k < 6; k++)
      send_point(12'($urandom_range(0, 700)), 12'($urandom_range(0, 700)));
    wait_drained();
    for (int k = 0; k < 4; k++)
      send_point(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    err_count     = 0;
    cycle_count   = 0;
    burst_left    = 3;
    sender_gaps   = 1'b1;
    rx_hold_req   = 0;
    cfg_field_w   = RST_FIELD_WIDTH;
    cfg_field_h   = RST_FIELD_HEIGHT;
    cfg_radius    = RST_KEEPOUT_RADIUS;
    cfg_spacing   = RST_GRID_SPACING;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_zero_cases();
    test_extreme_settings();
    test_random_points();
    test_backpressure();
    wait_drained();

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
